[src/rart_pkg.sv]
// shared constants, types and helpers for the range add / range max tree
package rart_pkg;

    localparam int LEAVES = 1024;
    localparam int NODES  = 2 * LEAVES;
    localparam int IDX_W  = $clog2(NODES);
    localparam int KW     = IDX_W + 1;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 32;
    localparam int DATA_W = 64;
    localparam int STK_D  = IDX_W;
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam int STK_AW = $clog2(STK_D);
    localparam int CLR_W  = IDX_W + 1;

    localparam logic [POS_W-1:0]  LAST_RESET = POS_W'(1023);
    localparam logic [DATA_W-1:0] SIGN_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_MAX = 1'b1;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [KW-1:0]     node_t;
    typedef logic [IDX_W-1:0]  addr_t;

    typedef struct packed {
        logic               func;
        pos_t               lo;
        pos_t               hi;
        logic [VAL_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        node_t k;
        pos_t  l;
        pos_t  r;
        logic  side;
        word_t left;
    } frame_t;

    function automatic word_t max_signed(word_t a, word_t b);
        return ($signed(b) > $signed(a)) ? b : a;
    endfunction

endpackage

[src/rart_if.sv]
// handshake channel interfaces for requests, results and configuration
interface rart_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [rart_pkg::POS_W-1:0]   lo;
    logic [rart_pkg::POS_W-1:0]   hi;
    logic signed [rart_pkg::VAL_W-1:0] value;

    modport source (output valid, func, lo, hi, value, input ready);
    modport sink   (input valid, func, lo, hi, value, output ready);
endinterface

interface rart_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [rart_pkg::DATA_W-1:0] max_value;

    modport source (output valid, max_value, input ready);
    modport sink   (input valid, max_value, output ready);
endinterface

interface rart_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rart_pkg::POS_W-1:0] last_index;

    modport source (output valid, last_index, input ready);
    modport sink   (input valid, last_index, output ready);
endinterface

[src/rart_ram.sv]
// generic single-write single-read synchronous ram, registered read data
module rart_ram #(
    parameter int W = 64,
    parameter int D = 2048
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/rart_ctrl.sv]
// tree walk sequencer: explicit stack, lazy tag push and node updates
module rart_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rart_pkg::req_t          req,
    input  rart_pkg::pos_t          last_index,
    output logic                    ready,
    output logic                    done_valid,
    input  logic                    done_ack,
    output rart_pkg::word_t         result,
    output rart_pkg::mem_req_t      max_req,
    output rart_pkg::mem_req_t      pend_req,
    input  rart_pkg::word_t         max_rd,
    input  rart_pkg::word_t         pend_rd
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_CHILD  = 12'b000000000100,
        S_PUSH   = 12'b000000001000,
        S_C0     = 12'b000000010000,
        S_C1     = 12'b000000100000,
        S_DECIDE = 12'b000001000000,
        S_RET    = 12'b000010000000,
        S_A0     = 12'b000100000000,
        S_A1     = 12'b001000000000,
        S_A2     = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [rart_pkg::CLR_W-1:0]  clr_reg, clr_next;
    logic                        func_reg, func_next;
    rart_pkg::pos_t              lo_reg, lo_next;
    rart_pkg::pos_t              hi_reg, hi_next;
    rart_pkg::word_t             v_reg, v_next;
    rart_pkg::node_t             k_reg, k_next;
    rart_pkg::pos_t              l_reg, l_next;
    rart_pkg::pos_t              r_reg, r_next;
    rart_pkg::word_t             cur_reg, cur_next;
    rart_pkg::word_t             t_reg, t_next;
    rart_pkg::word_t             ret_reg, ret_next;
    rart_pkg::word_t             a_reg, a_next;
    rart_pkg::word_t             res_reg, res_next;
    logic                        cov_reg, cov_next;
    logic [rart_pkg::SP_W-1:0]   sp_reg, sp_next;
    rart_pkg::frame_t            stk_reg [rart_pkg::STK_D];
    rart_pkg::frame_t            stk_next [rart_pkg::STK_D];

    rart_pkg::node_t             c;
    logic                        c_ok;
    logic [rart_pkg::POS_W:0]    lr_sum;
    rart_pkg::pos_t              mid;
    rart_pkg::pos_t              top_c;
    rart_pkg::pos_t              hi_c;
    rart_pkg::frame_t            f;
    logic [rart_pkg::POS_W:0]    f_sum;
    logic [rart_pkg::STK_AW-1:0] sp_top;
    rart_pkg::word_t             sum_w;

    assign c      = {k_reg[rart_pkg::KW-2:0], 1'b0};
    assign c_ok   = !c[rart_pkg::KW-1];
    assign lr_sum = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid    = lr_sum[rart_pkg::POS_W:1];
    assign sp_top = rart_pkg::STK_AW'(sp_reg - 1'b1);
    assign f      = stk_reg[sp_top];
    assign f_sum  = {1'b0, f.l} + {1'b0, f.r};

    assign ready      = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_DONE);
    assign result     = res_reg;

    always_comb
    begin
        if (32'(last_index) > rart_pkg::LEAVES - 1)
        begin
            top_c = rart_pkg::POS_W'(rart_pkg::LEAVES - 1);
        end
        else
        begin
            top_c = last_index;
        end
        hi_c = (req.hi > top_c) ? top_c : req.hi;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        func_next  = func_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        cur_next   = cur_reg;
        t_next     = t_reg;
        ret_next   = ret_reg;
        a_next     = a_reg;
        res_next   = res_reg;
        cov_next   = cov_reg;
        sp_next    = sp_reg;
        stk_next   = stk_reg;
        sum_w      = '0;
        max_req    = '{we: 1'b0, waddr: k_reg[rart_pkg::IDX_W-1:0], wdata: '0,
                       raddr: k_reg[rart_pkg::IDX_W-1:0]};
        pend_req   = max_req;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero one node of both stores per cycle
                max_req.we     = 1'b1;
                max_req.waddr  = clr_reg[rart_pkg::IDX_W-1:0];
                pend_req.we    = 1'b1;
                pend_req.waddr = clr_reg[rart_pkg::IDX_W-1:0];
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == rart_pkg::CLR_W'(rart_pkg::NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = req.func;
                    lo_next   = req.lo;
                    hi_next   = hi_c;
                    v_next    = {{(rart_pkg::DATA_W-rart_pkg::VAL_W){req.value[rart_pkg::VAL_W-1]}},
                                 req.value};
                    k_next    = rart_pkg::KW'(1);
                    l_next    = '0;
                    r_next    = top_c;
                    sp_next   = '0;
                    if (req.lo > hi_c)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHILD;
                    end
                end
            end
            S_CHILD:
            begin
                if (!k_reg[rart_pkg::KW-1])
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    ret_next   = rart_pkg::SIGN_MIN;
                    state_next = S_RET;
                end
            end
            S_PUSH:
            begin
                sum_w    = max_rd + pend_rd;
                cur_next = sum_w;
                t_next   = pend_rd;
                cov_next = 1'b0;
                if (pend_rd != '0)
                begin
                    max_req.we     = 1'b1;
                    max_req.wdata  = sum_w;
                    pend_req.we    = 1'b1;
                    pend_req.wdata = '0;
                end
                if (pend_rd != '0 && l_reg != r_reg && c_ok)
                begin
                    pend_req.raddr = c[rart_pkg::IDX_W-1:0];
                    state_next     = S_C0;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_C0:
            begin
                pend_req.we    = 1'b1;
                pend_req.waddr = c[rart_pkg::IDX_W-1:0];
                pend_req.wdata = pend_rd + t_reg;
                pend_req.raddr = c[rart_pkg::IDX_W-1:0] | rart_pkg::IDX_W'(1);
                state_next     = S_C1;
            end
            S_C1:
            begin
                pend_req.we    = 1'b1;
                pend_req.waddr = c[rart_pkg::IDX_W-1:0] | rart_pkg::IDX_W'(1);
                pend_req.wdata = pend_rd + t_reg;
                state_next     = cov_reg ? S_RET : S_DECIDE;
            end
            S_DECIDE:
            begin
                if (r_reg < lo_reg || hi_reg < l_reg)
                begin
                    ret_next   = rart_pkg::SIGN_MIN;
                    state_next = S_RET;
                end
                else if (lo_reg <= l_reg && r_reg <= hi_reg)
                begin
                    if (func_reg == rart_pkg::FUNC_MAX)
                    begin
                        ret_next   = cur_reg;
                        state_next = S_RET;
                    end
                    else
                    begin
                        // covered add: the tag goes straight into this node
                        max_req.we    = 1'b1;
                        max_req.wdata = cur_reg + v_reg;
                        t_next        = v_reg;
                        cov_next      = 1'b1;
                        if (v_reg != '0 && l_reg != r_reg && c_ok)
                        begin
                            pend_req.raddr = c[rart_pkg::IDX_W-1:0];
                            state_next     = S_C0;
                        end
                        else
                        begin
                            state_next = S_RET;
                        end
                    end
                end
                else
                begin
                    stk_next[sp_reg[rart_pkg::STK_AW-1:0]] =
                        '{k: k_reg, l: l_reg, r: r_reg, side: 1'b0, left: '0};
                    sp_next    = sp_reg + 1'b1;
                    k_next     = c;
                    r_next     = mid;
                    state_next = S_CHILD;
                end
            end
            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    res_next   = (func_reg == rart_pkg::FUNC_MAX) ? ret_reg : '0;
                    state_next = S_DONE;
                end
                else if (!f.side)
                begin
                    stk_next[sp_top].side = 1'b1;
                    stk_next[sp_top].left = ret_reg;
                    k_next     = {f.k[rart_pkg::KW-2:0], 1'b1};
                    l_next     = rart_pkg::POS_W'(f_sum[rart_pkg::POS_W:1] + 1'b1);
                    r_next     = f.r;
                    state_next = S_CHILD;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    k_next  = f.k;
                    l_next  = f.l;
                    r_next  = f.r;
                    if (func_reg == rart_pkg::FUNC_MAX)
                    begin
                        ret_next   = rart_pkg::max_signed(f.left, ret_reg);
                        state_next = S_RET;
                    end
                    else
                    begin
                        state_next = S_A0;
                    end
                end
            end
            S_A0:
            begin
                max_req.raddr = c[rart_pkg::IDX_W-1:0];
                state_next    = S_A1;
            end
            S_A1:
            begin
                a_next        = c_ok ? max_rd : rart_pkg::SIGN_MIN;
                max_req.raddr = c[rart_pkg::IDX_W-1:0] | rart_pkg::IDX_W'(1);
                state_next    = S_A2;
            end
            S_A2:
            begin
                max_req.we    = 1'b1;
                max_req.wdata = rart_pkg::max_signed(a_reg,
                                    c_ok ? max_rd : rart_pkg::SIGN_MIN);
                state_next    = S_RET;
            end
            S_DONE:
            begin
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            cov_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            cov_reg   <= cov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        v_reg    <= v_next;
        k_reg    <= k_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        cur_reg  <= cur_next;
        t_reg    <= t_next;
        ret_reg  <= ret_next;
        a_reg    <= a_next;
        res_reg  <= res_next;
        stk_reg  <= stk_next;
    end

endmodule

[src/range_add_range_max_tree.sv]
// top level of the range add / range max lazy segment tree
//
//  channel | dir | fields                      | transaction
//  --------+-----+-----------------------------+-----------------------------
//  req     | in  | func, lo, hi, value         | one add or one max query
//  rsp     | out | max_value                   | one result per request
//  cfg     | in  | last_index                  | write of the tree bound
//
// each visited node is read, any pending tag pushed into both children and,
// for an add, the children's maxima merged back; an item visits up to four
// nodes per level, and each node store has a single read port, so these
// steps run one after another
// after reset a clearing pass zeroes all 2048 nodes of both stores; req.ready
// stays low during it, cfg writes are taken throughout
// a finished result sits in the output register, so the next request is
// taken while rsp is stalled
module range_add_range_max_tree (
    input  logic         clk,
    input  logic         rst_n,
    rart_req_if.sink     req,
    rart_rsp_if.source   rsp,
    rart_cfg_if.sink     cfg
);

    rart_pkg::pos_t     last_index_reg;
    logic               rsp_valid_reg;
    rart_pkg::word_t    rsp_data_reg;

    logic               ctrl_ready;
    logic               done_valid;
    logic               done_ack;
    rart_pkg::word_t    result;
    rart_pkg::req_t     req_bus;
    rart_pkg::mem_req_t max_req;
    rart_pkg::mem_req_t pend_req;
    rart_pkg::word_t    max_rd;
    rart_pkg::word_t    pend_rd;

    // config write is always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= rart_pkg::LAST_RESET;
        end
        else if (cfg.valid)
        begin
            last_index_reg <= cfg.last_index;
        end
    end

    // request side goes straight to the sequencer
    assign req.ready = ctrl_ready;
    assign req_bus   = '{func: req.func, lo: req.lo, hi: req.hi, value: req.value};

    // result register frees the sequencer while rsp is stalled
    assign done_ack = done_valid && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done_ack)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ack)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.max_value = rsp_data_reg;

    rart_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req.valid && ctrl_ready),
        .req        (req_bus),
        .last_index (last_index_reg),
        .ready      (ctrl_ready),
        .done_valid (done_valid),
        .done_ack   (done_ack),
        .result     (result),
        .max_req    (max_req),
        .pend_req   (pend_req),
        .max_rd     (max_rd),
        .pend_rd    (pend_rd)
    );

    // per-node maximum
    rart_ram #(
        .W (rart_pkg::DATA_W),
        .D (rart_pkg::NODES)
    ) u_max_ram (
        .clk   (clk),
        .we    (max_req.we),
        .waddr (max_req.waddr),
        .wdata (max_req.wdata),
        .raddr (max_req.raddr),
        .rdata (max_rd)
    );

    // per-node pending addition
    rart_ram #(
        .W (rart_pkg::DATA_W),
        .D (rart_pkg::NODES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_req.we),
        .waddr (pend_req.waddr),
        .wdata (pend_req.wdata),
        .raddr (pend_req.raddr),
        .rdata (pend_rd)
    );

endmodule

[tb/range_add_range_max_tree_tb.sv]
// self-checking testbench for the range add / range max lazy segment tree
module range_add_range_max_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_NODES = 2 * rart_pkg::LEAVES;

    logic clk;
    logic rst_n;

    rart_req_if req ();
    rart_rsp_if rsp ();
    rart_cfg_if cfg ();

    range_add_range_max_tree DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // shadow copy of the tree state and the bound register
    logic [63:0] shadow_max [TREE_NODES];
    logic [63:0] shadow_tag [TREE_NODES];
    logic [9:0]  shadow_last;

    // expected max_value per request, oldest first
    logic [63:0] expected_max_q [$];
    int          fail_count;
    bit          rsp_stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous limit: clearing pass plus worst case per item with stalls
    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] smax(logic [63:0] a, logic [63:0] b);
        return ($signed(b) > $signed(a)) ? b : a;
    endfunction

    // append one expected result
    function automatic void queue_expected(logic [63:0] e);
        expected_max_q = {expected_max_q, e};
    endfunction

    // apply a pending tag to the node and hand it to the children
    function automatic void push_down(int k, int l, int r);
        logic [63:0] t;
        t = shadow_tag[k];
        if (t == 64'd0)
            return;
        shadow_max[k] += t;
        if (l != r)
        begin
            if (2 * k < TREE_NODES)
                shadow_tag[2 * k] += t;
            if (2 * k + 1 < TREE_NODES)
                shadow_tag[2 * k + 1] += t;
        end
        shadow_tag[k] = 64'd0;
    endfunction

    function automatic logic [63:0] tree_max(int k, int l, int r, int lo, int hi);
        int mid;
        if (k >= TREE_NODES)
            return rart_pkg::SIGN_MIN;
        push_down(k, l, r);
        if (r < lo || hi < l)
            return rart_pkg::SIGN_MIN;
        if (lo <= l && r <= hi)
            return shadow_max[k];
        mid = (l + r) >> 1;
        return smax(tree_max(2 * k, l, mid, lo, hi),
                    tree_max(2 * k + 1, mid + 1, r, lo, hi));
    endfunction

    function automatic void tree_add(int k, int l, int r, int lo, int hi,
                                     logic [63:0] v);
        int mid;
        logic [63:0] a;
        logic [63:0] b;
        if (k >= TREE_NODES)
            return;
        push_down(k, l, r);
        if (r < lo || hi < l)
            return;
        if (lo <= l && r <= hi)
        begin
            shadow_tag[k] += v;
            push_down(k, l, r);
            return;
        end
        mid = (l + r) >> 1;
        tree_add(2 * k, l, mid, lo, hi, v);
        tree_add(2 * k + 1, mid + 1, r, lo, hi, v);
        a = (2 * k < TREE_NODES) ? shadow_max[2 * k] : rart_pkg::SIGN_MIN;
        b = (2 * k + 1 < TREE_NODES) ? shadow_max[2 * k + 1] : rart_pkg::SIGN_MIN;
        shadow_max[k] = smax(a, b);
    endfunction

    // expected result of one request, updating the shadow tree
    function automatic logic [63:0] predict_range_op(logic f, int lo, int hi,
                                                     logic [31:0] value);
        int top;
        top = shadow_last;
        if (top > rart_pkg::LEAVES - 1)
            top = rart_pkg::LEAVES - 1;
        if (hi > top)
            hi = top;
        if (lo > hi)
            return 64'd0;
        if (f == rart_pkg::FUNC_ADD)
        begin
            tree_add(1, 0, top, lo, hi, {{32{value[31]}}, value});
            return 64'd0;
        end
        return tree_max(1, 0, top, lo, hi);
    endfunction

    // receiver: stalls on its own pattern and checks every result transaction
    initial
    begin
        int phase;
        phase = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_max_q.size() == 0)
                begin
                    $error("max_value: no result expected, got %0d", rsp.max_value);
                    fail_count++;
                end
                else
                begin
                    logic [63:0] exp_v;
                    exp_v = expected_max_q.pop_front();
                    if (rsp.max_value !== exp_v)
                    begin
                        $error("max_value: expected %0d actual %0d",
                               $signed(exp_v), rsp.max_value);
                        fail_count++;
                    end
                end
            end
            // stall pattern: long open windows, then bursts of random holds
            phase = (phase + 1) % 64;
            if (!rsp_stall_enable || phase < 24)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    typedef struct {
        logic        f;
        int          lo;
        int          hi;
        logic [31:0] value;
        bit          typed;   // expected value typed in below
        logic [63:0] expv;
    } stim_row_t;

    stim_row_t directed [$];
    int        burst_left;

    // send one request transaction, gaps between random-length bursts
    task automatic send_request(logic f, int lo, int hi, logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req.valid <= 1'b1;
        req.func  <= f;
        req.lo    <= lo[9:0];
        req.hi    <= hi[9:0];
        req.value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (expected_max_q.size() != 0)
            @(posedge clk);
        // let the block settle before touching the bound register
        repeat (200) @(posedge clk);
    endtask

    task automatic write_bound(logic [9:0] bound);
        cfg.valid      <= 1'b1;
        cfg.last_index <= bound;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        shadow_last = bound;
    endtask

    function automatic void add_row(logic f, int lo, int hi, logic [31:0] v,
                                    bit typed, logic [63:0] e);
        stim_row_t row;
        row.f = f; row.lo = lo; row.hi = hi; row.value = v;
        row.typed = typed; row.expv = e;
        directed = {directed, row};
    endfunction

    initial
    begin
        logic [63:0] predicted;
        logic [9:0]  bounds [5];
        fail_count       = 0;
        burst_left       = 0;
        rsp_stall_enable = 1'b1;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.func         = rart_pkg::FUNC_ADD;
        req.lo           = '0;
        req.hi           = '0;
        req.value        = '0;
        cfg.valid        = 1'b0;
        cfg.last_index   = '0;
        for (int i = 0; i < TREE_NODES; i++)
        begin
            shadow_max[i] = '0;
            shadow_tag[i] = '0;
        end
        shadow_last = rart_pkg::LAST_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: after-reset zeros, empty ranges, extremes
        add_row(rart_pkg::FUNC_MAX, 0, 1023, 32'd0, 1, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 5, 4, 32'd0, 1, 64'd0);
        add_row(rart_pkg::FUNC_ADD, 9, 3, 32'h7fff_ffff, 1, 64'd0);
        add_row(rart_pkg::FUNC_ADD, 0, 1023, 32'h7fff_ffff, 1, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 1023, 1023, 32'd0, 1, 64'h0000_0000_7fff_ffff);
        add_row(rart_pkg::FUNC_ADD, 0, 0, 32'h8000_0000, 1, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 0, 0, 32'd0, 1, 64'hffff_ffff_ffff_ffff);
        add_row(rart_pkg::FUNC_ADD, 0, 511, 32'h8000_0000, 0, 64'd0);
        add_row(rart_pkg::FUNC_ADD, 0, 511, 32'h8000_0000, 0, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 0, 511, 32'hffff_ffff, 0, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 100, 700, 32'd0, 0, 64'd0);
        add_row(rart_pkg::FUNC_ADD, 512, 1023, 32'hffff_ffff, 0, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 511, 512, 32'd0, 0, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 1023, 0, 32'd0, 1, 64'd0);
        add_row(rart_pkg::FUNC_ADD, 3, 3, 32'h5555_aaaa, 0, 64'd0);
        add_row(rart_pkg::FUNC_MAX, 0, 1023, 32'd0, 0, 64'd0);
        foreach (directed[i])
        begin
            predicted = predict_range_op(directed[i].f, directed[i].lo,
                                         directed[i].hi, directed[i].value);
            if (directed[i].typed && predicted !== directed[i].expv)
            begin
                $error("max_value: expected %0d actual %0d (predictor)",
                       $signed(directed[i].expv), $signed(predicted));
                fail_count++;
            end
            queue_expected(directed[i].expv & {64{directed[i].typed}}
                           | predicted & {64{!directed[i].typed}});
            send_request(directed[i].f, directed[i].lo, directed[i].hi,
                         directed[i].value);
        end
        drain_results();

        // random phases over several tree bounds, extremes included
        bounds[0] = 10'd0;    bounds[1] = 10'd1;    bounds[2] = 10'd37;
        bounds[3] = 10'd1023; bounds[4] = 10'd300;
        for (int p = 0; p < 5; p++)
        begin
            write_bound(bounds[p]);
            rsp_stall_enable = (p != 2);
            for (int n = 0; n < 120; n++)
            begin
                logic        f;
                int          lo;
                int          hi;
                logic [31:0] v;
                f = 1'($urandom_range(0, 1));
                v = $urandom;
                if ($urandom_range(0, 3) == 0)
                begin
                    lo = $urandom_range(0, 1023);
                    hi = $urandom_range(0, 1023);
                end
                else
                begin
                    lo = $urandom_range(0, bounds[p]);
                    hi = $urandom_range(lo, bounds[p]);
                end
                if ($urandom_range(0, 1) == 0)
                    v = $signed(v) >>> $urandom_range(0, 31);
                queue_expected(predict_range_op(f, lo, hi, v));
                send_request(f, lo, hi, v);
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
